@@ rtl/core/chd_pkg.sv @@
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types, codes and defaults of the canonical huffman decoder core.
// ----------------------------------------------------------------------------
package chd_pkg;

    localparam int MAX_CODE_LENGTH_DEF = 16;
    localparam int SYMBOL_COUNT_DEF    = 256;

    localparam logic [1:0] OP_SYM  = 2'd0;
    localparam logic [1:0] OP_CNT  = 2'd1;
    localparam logic [1:0] OP_DATA = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] slot;
        logic [8:0] payload;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] symbol;
        logic       bad_code;
        logic       last;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE0,
        ST_PRE1,
        ST_BIT,
        ST_EMIT,
        ST_FLUSH
    } t_state;

endpackage

@@ rtl/core/chd_ram.sv @@
// ----------------------------------------------------------------------------
// chd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module chd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/chd_ctrl.sv @@
// ----------------------------------------------------------------------------
// chd_ctrl
// Bit-serial decode sequencer: table loads, count reads per bit, canonical
// code compare and symbol fetch.
// ----------------------------------------------------------------------------
module chd_ctrl
    import chd_pkg::*;
#(
    parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF,
    parameter int SYMBOL_COUNT    = SYMBOL_COUNT_DEF,
    localparam int LW = $clog2(MAX_CODE_LENGTH + 1),
    localparam int SW = $clog2(SYMBOL_COUNT)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_in_beat        i_in,
    output logic            o_res_valid,
    input  logic            i_res_space,
    output t_out_beat       o_res,
    output logic            o_sym_we,
    output logic [SW-1:0]   o_sym_waddr,
    output logic [7:0]      o_sym_wdata,
    output logic            o_sym_re,
    output logic [SW-1:0]   o_sym_raddr,
    input  logic [7:0]      i_sym_rdata,
    output logic            o_cnt_we,
    output logic [LW-1:0]   o_cnt_waddr,
    output logic [8:0]      o_cnt_wdata,
    output logic            o_cnt_re,
    output logic [LW-1:0]   o_cnt_raddr,
    input  logic [8:0]      i_cnt_rdata
);

    localparam int FW = MAX_CODE_LENGTH + 1;
    localparam int CW = (FW > 10) ? FW : 10;
    localparam logic [CW:0]   HALF_CAP = (CW + 1)'((1 << MAX_CODE_LENGTH) - 1);
    localparam logic [CW-1:0] SYM_LIM  = CW'(SYMBOL_COUNT);

    t_state                     r_state, n_state;
    logic [MAX_CODE_LENGTH-1:0] r_code;
    logic [FW-1:0]              r_first;
    logic [8:0]                 r_base;
    logic [LW-1:0]              r_len;
    logic [8:0]                 r_lo;
    logic [7:0]                 r_byte;
    logic [2:0]                 r_bit;
    logic [MAX_CODE_LENGTH:0]   r_cnt_vld;
    logic                       r_hi_vld;
    logic                       r_pend_bad;
    logic                       r_pend_last;
    logic                       r_pend_ram;
    logic [7:0]                 r_held_sym;
    logic                       r_held_bad;
    logic                       r_held_vld;

    logic                       w_accept;
    logic                       w_emit_go;
    logic                       w_bit;
    logic [8:0]                 w_hi;
    logic [8:0]                 w_count;
    logic [MAX_CODE_LENGTH:0]   w_shift;
    logic [FW-1:0]              w_code_x;
    logic [FW-1:0]              w_diff;
    logic                       w_match;
    logic [CW-1:0]              w_pos;
    logic                       w_in_range;
    logic [LW-1:0]              w_len_n;
    logic                       w_full;
    logic [9:0]                 w_base_sum;
    logic [8:0]                 w_base_n;
    logic [CW:0]                w_first_sum;
    logic [FW-1:0]              w_first_n;

    assign w_accept = i_in_valid && (r_state == ST_IDLE);

    // a result is held back one step so the final one of a byte can carry last
    assign w_emit_go = !r_held_vld || i_res_space;

    // canonical compare for the current bit
    always_comb begin
        w_bit       = r_byte[r_bit];
        w_hi        = r_hi_vld ? i_cnt_rdata : '0;
        w_count     = (w_hi > r_lo) ? (w_hi - r_lo) : '0;
        w_shift     = {r_code, w_bit};
        w_code_x    = {1'b0, w_shift[MAX_CODE_LENGTH-1:0]};
        w_diff      = w_code_x - r_first;
        w_match     = (w_code_x >= r_first) && (CW'(w_diff) < CW'(w_count));
        w_pos       = CW'(r_base) + CW'(w_diff);
        w_in_range  = w_pos < SYM_LIM;
        w_len_n     = r_len + LW'(1);
        w_full      = w_len_n >= LW'(MAX_CODE_LENGTH);
        w_base_sum  = 10'(r_base) + 10'(w_count);
        w_base_n    = (w_base_sum > 10'd511) ? 9'h1FF : w_base_sum[8:0];
        w_first_sum = (CW + 1)'(r_first) + (CW + 1)'(w_count);
        w_first_n   = (w_first_sum > HALF_CAP) ? '1
                                               : {w_first_sum[FW-2:0], 1'b0};
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_in.opcode == OP_DATA)) begin
                    n_state = ST_PRE0;
                end
            end
            ST_PRE0: begin
                n_state = ST_PRE1;
            end
            ST_PRE1: begin
                n_state = ST_BIT;
            end
            ST_BIT: begin
                if (w_match || w_full) begin
                    n_state = ST_EMIT;
                end else if (r_bit == 3'd0) begin
                    n_state = r_held_vld ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (w_emit_go) begin
                    n_state = r_pend_last ? ST_FLUSH : ST_BIT;
                end
            end
            ST_FLUSH: begin
                if (i_res_space) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_sym_we    = 1'b0;
        o_sym_re    = 1'b0;
        o_cnt_we    = 1'b0;
        o_cnt_re    = 1'b0;
        o_cnt_raddr = r_len;
        o_sym_raddr = w_pos[SW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_sym_we   = i_in_valid && (i_in.opcode == OP_SYM)
                             && ({1'b0, i_in.slot} < 9'(SYMBOL_COUNT));
                o_cnt_we   = i_in_valid && (i_in.opcode == OP_CNT)
                             && (i_in.slot != 8'd0)
                             && (i_in.slot <= 8'(MAX_CODE_LENGTH));
            end
            ST_PRE0: begin
                o_cnt_re    = 1'b1;
                o_cnt_raddr = r_len;
            end
            ST_PRE1: begin
                o_cnt_re    = 1'b1;
                o_cnt_raddr = w_len_n;
            end
            ST_BIT: begin
                o_cnt_re    = 1'b1;
                o_cnt_raddr = (w_match || w_full) ? LW'(1) : (w_len_n + LW'(1));
                o_sym_re    = w_match && w_in_range;
            end
            ST_EMIT: begin
                o_res_valid = r_held_vld;
            end
            ST_FLUSH: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign o_sym_waddr     = i_in.slot[SW-1:0];
    assign o_sym_wdata     = i_in.payload[7:0];
    assign o_cnt_waddr     = i_in.slot[LW-1:0];
    assign o_cnt_wdata     = i_in.payload;
    assign o_res.symbol    = r_held_sym;
    assign o_res.bad_code  = r_held_bad;
    assign o_res.last      = (r_state == ST_FLUSH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
        end else if (o_cnt_we) begin
            r_cnt_vld[o_cnt_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_vld <= 1'b0;
        end else if ((r_state == ST_EMIT) && w_emit_go) begin
            r_held_vld <= 1'b1;
        end else if ((r_state == ST_FLUSH) && i_res_space) begin
            r_held_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cnt_re) begin
            r_hi_vld <= r_cnt_vld[o_cnt_raddr];
        end
        if (w_accept) begin
            r_byte <= i_in.payload[7:0];
            r_bit  <= 3'd7;
        end
        if (r_state == ST_PRE1) begin
            r_lo <= w_hi;
        end
        if (r_state == ST_BIT) begin
            r_bit       <= r_bit - 3'd1;
            r_pend_last <= (r_bit == 3'd0);
            r_pend_bad  <= !w_match;
            r_pend_ram  <= w_match && w_in_range;
            r_lo        <= (w_match || w_full) ? 9'd0 : w_hi;
        end
        if ((r_state == ST_EMIT) && w_emit_go) begin
            r_held_sym <= r_pend_ram ? i_sym_rdata : 8'd0;
            r_held_bad <= r_pend_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code  <= '0;
            r_first <= '0;
            r_base  <= '0;
            r_len   <= '0;
        end else if (r_state == ST_BIT) begin
            if (w_match || w_full) begin
                r_code  <= '0;
                r_first <= '0;
                r_base  <= '0;
                r_len   <= '0;
            end else begin
                r_code  <= w_shift[MAX_CODE_LENGTH-1:0];
                r_first <= w_first_n;
                r_base  <= w_base_n;
                r_len   <= w_len_n;
            end
        end
    end

endmodule

@@ rtl/core/canonical_huffman_decoder_core.sv @@
// ----------------------------------------------------------------------------
// canonical_huffman_decoder_core
// Canonical huffman decoder: table loads and bit-serial decode of data bytes.
// ----------------------------------------------------------------------------
// Load beats (symbol entry or cumulative count write) are each taken in the
// idle state. A data beat passes from its accept through the PRE0 and PRE1
// states, which fetch the count bounds from the count memory, then one BIT
// state per compressed bit, set by one count-memory read per bit, and one
// EMIT state per result for its symbol-memory read, plus a closing FLUSH
// state when it produces any result; EMIT and FLUSH wait while the output is
// stalled. Every result is held back one step so the final one of a byte can
// carry last, which costs the extra closing state. Count entries carry valid
// bits, so there is no clearing pass after reset. Results go through an output
// register, so the next beat is taken while a result still waits.
module canonical_huffman_decoder_core
    import chd_pkg::*;
#(
    parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF,
    parameter int SYMBOL_COUNT    = SYMBOL_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out
);

    localparam int LW = $clog2(MAX_CODE_LENGTH + 1);
    localparam int SW = $clog2(SYMBOL_COUNT);

    logic            sym_we, sym_re, cnt_we, cnt_re;
    logic [SW-1:0]   sym_waddr, sym_raddr;
    logic [7:0]      sym_wdata, sym_rdata;
    logic [LW-1:0]   cnt_waddr, cnt_raddr;
    logic [8:0]      cnt_wdata, cnt_rdata;
    logic            res_valid, res_space;
    t_out_beat       res;
    logic            r_out_vld;
    t_out_beat       r_out;

    assign res_space = !r_out_vld || i_out_ready;

    chd_ram #(.WIDTH(8), .DEPTH(SYMBOL_COUNT)) u_sym_ram (
        .i_clk   (i_clk),
        .i_we    (sym_we),
        .i_waddr (sym_waddr),
        .i_wdata (sym_wdata),
        .i_re    (sym_re),
        .i_raddr (sym_raddr),
        .o_rdata (sym_rdata)
    );

    chd_ram #(.WIDTH(9), .DEPTH(MAX_CODE_LENGTH + 1)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    chd_ctrl #(
        .MAX_CODE_LENGTH (MAX_CODE_LENGTH),
        .SYMBOL_COUNT    (SYMBOL_COUNT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_res_valid (res_valid),
        .i_res_space (res_space),
        .o_res       (res),
        .o_sym_we    (sym_we),
        .o_sym_waddr (sym_waddr),
        .o_sym_wdata (sym_wdata),
        .o_sym_re    (sym_re),
        .o_sym_raddr (sym_raddr),
        .i_sym_rdata (sym_rdata),
        .o_cnt_we    (cnt_we),
        .o_cnt_waddr (cnt_waddr),
        .o_cnt_wdata (cnt_wdata),
        .o_cnt_re    (cnt_re),
        .o_cnt_raddr (cnt_raddr),
        .i_cnt_rdata (cnt_rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_space) begin
            r_out_vld <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_space && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule
